[hw/rtl/assert_macros.svh]
// Assertion macros used by the checker module of the run-length encoder.
// The macros expect a signal named clk, and CHK_ASSERT also rst_n, in the scope where they are used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define CHK_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every rising edge, reset included.
`define CHK_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[hw/rtl/rgb_rle_pkg.sv]
// Shared widths, constants and types of the RGB565 run-length encoder.
// Used by the channel interfaces, the encoder and its checker; no dependencies.
package rgb_rle_pkg;

  localparam int PIX_W = 16;
  localparam int LEN_W = 16;
  localparam int NUM_W = 21;

  // A run is closed as soon as its length reaches this value.
  localparam logic [LEN_W-1:0] RUN_MAX = 16'hFFFF;

  // Result queue: two entries of room are needed before a pixel may be processed.
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic [LEN_W-1:0] run_length;
    logic [PIX_W-1:0] run_value;
    logic [NUM_W-1:0] pair_number;
    logic             last_pair;
  } pair_t;

endpackage

[hw/rtl/rgb_rle_pix_if.sv]
// Pixel channel of the run-length encoder: valid/ready with one pixel per item.
// Depends on rgb_rle_pkg for the pixel width.
interface rgb_rle_pix_if;
  logic                         valid;
  logic                         ready;
  logic [rgb_rle_pkg::PIX_W-1:0] pixel;
  logic                         frame_end;

  modport source (output valid, output pixel, output frame_end, input ready);
  modport sink   (input valid, input pixel, input frame_end, output ready);
endinterface

[hw/rtl/rgb_rle_pair_if.sv]
// Result channel of the run-length encoder: valid/ready with one run pair per item.
// Depends on rgb_rle_pkg for the field widths.
interface rgb_rle_pair_if;
  logic                          valid;
  logic                          ready;
  logic [rgb_rle_pkg::LEN_W-1:0] run_length;
  logic [rgb_rle_pkg::PIX_W-1:0] run_value;
  logic [rgb_rle_pkg::NUM_W-1:0] pair_number;
  logic                          last_pair;

  modport source (output valid, output run_length, output run_value, output pair_number,
                  output last_pair, input ready);
  modport sink   (input valid, input run_length, input run_value, input pair_number,
                  input last_pair, output ready);
endinterface

[hw/rtl/rgb565_run_length_encoder.sv]
// RGB565 run-length encoder: takes one pixel per item and emits (length, value) pairs
// numbered from 1 within each frame, the final pair of a frame marked last_pair.
// Depends on rgb_rle_pkg, rgb_rle_pix_if and rgb_rle_pair_if.
//
// The encoder accepts one pixel every clock cycle while its four-entry result queue has
// room for two pairs. A pixel sits in an input register, is compared with the open run
// there, and any pairs it closes are written to the queue when it leaves that register,
// so a pair passes the input register and then the queue before it reaches the output.
// The output drains one pair per cycle while the receiver is ready; a frame-end pixel that
// closes two pairs fills two queue entries, and with a ready receiver a steady stream
// of single pairs runs at one item per cycle. There is no start-up pass after reset.
module rgb565_run_length_encoder (
  input  logic                  clk,
  input  logic                  rst_n,
  rgb_rle_pix_if.sink           in_chan,
  rgb_rle_pair_if.source        out_chan
);

  // Input register
  logic                          stage_vld_r, stage_vld_nxt;
  logic [rgb_rle_pkg::PIX_W-1:0] px_r;
  logic                          fend_r;

  // Run state
  logic [rgb_rle_pkg::PIX_W-1:0] open_val_r, open_val_nxt;
  logic [rgb_rle_pkg::LEN_W-1:0] open_len_r, open_len_nxt;
  logic [rgb_rle_pkg::NUM_W-1:0] pairs_r, pairs_nxt;

  // Result queue
  rgb_rle_pkg::pair_t              fifo_r [rgb_rle_pkg::FIFO_DEPTH];
  logic [rgb_rle_pkg::FIFO_AW-1:0] wr_ptr_r, wr_ptr_nxt, wr_ptr_plus;
  logic [rgb_rle_pkg::FIFO_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [rgb_rle_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;

  logic                          in_acc, advance, pop;
  logic                          close_a, close_b;
  logic [rgb_rle_pkg::LEN_W-1:0] len_mid;
  logic [1:0]                    push_n;
  rgb_rle_pkg::pair_t            pair_a, pair_b;

  assign advance = stage_vld_r &&
                   (cnt_r <= rgb_rle_pkg::CNT_W'(rgb_rle_pkg::FIFO_DEPTH - 2));
  assign in_chan.ready = !stage_vld_r || advance;
  assign in_acc  = in_chan.valid && in_chan.ready;
  assign pop     = out_chan.valid && out_chan.ready;

  always_comb begin
    // A differing pixel closes the open run before it is counted.
    close_a = (open_len_r != '0) && (px_r != open_val_r);
    if ((open_len_r == '0) || close_a) begin
      len_mid = rgb_rle_pkg::LEN_W'(1);
    end else begin
      len_mid = open_len_r + rgb_rle_pkg::LEN_W'(1);
    end
    close_b = (len_mid == rgb_rle_pkg::RUN_MAX) || fend_r;

    pair_a.run_length  = open_len_r;
    pair_a.run_value   = open_val_r;
    pair_a.pair_number = pairs_r + rgb_rle_pkg::NUM_W'(1);
    pair_a.last_pair   = 1'b0;

    pair_b.run_length  = len_mid;
    pair_b.run_value   = px_r;
    pair_b.pair_number = pairs_r + rgb_rle_pkg::NUM_W'(close_a) + rgb_rle_pkg::NUM_W'(1);
    pair_b.last_pair   = fend_r;

    push_n = advance ? ({1'b0, close_a} + {1'b0, close_b}) : 2'd0;
  end

  always_comb begin
    stage_vld_nxt = stage_vld_r;
    if (in_acc) begin
      stage_vld_nxt = 1'b1;
    end else if (advance) begin
      stage_vld_nxt = 1'b0;
    end

    open_val_nxt = open_val_r;
    open_len_nxt = open_len_r;
    pairs_nxt    = pairs_r;
    if (advance) begin
      open_val_nxt = px_r;
      open_len_nxt = close_b ? '0 : len_mid;
      pairs_nxt    = fend_r ? '0 : (pairs_r + rgb_rle_pkg::NUM_W'(push_n));
    end

    wr_ptr_plus = wr_ptr_r + rgb_rle_pkg::FIFO_AW'(1);
    wr_ptr_nxt  = wr_ptr_r + rgb_rle_pkg::FIFO_AW'(push_n);
    rd_ptr_nxt  = rd_ptr_r + rgb_rle_pkg::FIFO_AW'(pop);
    cnt_nxt     = cnt_r + rgb_rle_pkg::CNT_W'(push_n) - rgb_rle_pkg::CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_vld_r <= 1'b0;
      open_val_r  <= '0;
      open_len_r  <= '0;
      pairs_r     <= '0;
      wr_ptr_r    <= '0;
      rd_ptr_r    <= '0;
      cnt_r       <= '0;
    end else begin
      stage_vld_r <= stage_vld_nxt;
      open_val_r  <= open_val_nxt;
      open_len_r  <= open_len_nxt;
      pairs_r     <= pairs_nxt;
      wr_ptr_r    <= wr_ptr_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      px_r   <= in_chan.pixel;
      fend_r <= in_chan.frame_end;
    end
  end

  // The second pair of an item goes one slot after the first.
  always_ff @(posedge clk) begin
    if (advance) begin
      if (close_a) begin
        fifo_r[wr_ptr_r] <= pair_a;
      end
      if (close_b) begin
        fifo_r[close_a ? wr_ptr_plus : wr_ptr_r] <= pair_b;
      end
    end
  end

  assign out_chan.valid       = (cnt_r != '0);
  assign out_chan.run_length  = fifo_r[rd_ptr_r].run_length;
  assign out_chan.run_value   = fifo_r[rd_ptr_r].run_value;
  assign out_chan.pair_number = fifo_r[rd_ptr_r].pair_number;
  assign out_chan.last_pair   = fifo_r[rd_ptr_r].last_pair;

endmodule

[hw/rtl/rgb_rle_chk.sv]
// Port-level checker of the RGB565 run-length encoder, bound to its top level.
// Depends on rgb_rle_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rgb_rle_chk (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [rgb_rle_pkg::LEN_W-1:0] run_length,
  input logic [rgb_rle_pkg::PIX_W-1:0] run_value,
  input logic [rgb_rle_pkg::NUM_W-1:0] pair_number,
  input logic                          last_pair
);

  logic                                                             stalled;
  logic [rgb_rle_pkg::LEN_W+rgb_rle_pkg::PIX_W+rgb_rle_pkg::NUM_W:0] pair_bits;

  assign stalled   = out_valid && !out_ready;
  assign pair_bits = {run_length, run_value, pair_number, last_pair};

  // Reset empties the result queue by the next edge.
  `CHK_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid, "result offered after reset")

  // Every pair covers at least one pixel.
  `CHK_ASSERT(a_len_nonzero, out_valid |-> (run_length != '0), "pair of zero length")

  `CHK_ASSERT(a_valid_hold, stalled |=> out_valid, "result withdrawn")

  `CHK_ASSERT(a_payload_hold, stalled |=> $stable(pair_bits), "stalled result changed")

endmodule

bind rgb565_run_length_encoder rgb_rle_chk u_rgb_rle_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_chan.valid),
  .out_ready   (out_chan.ready),
  .run_length  (out_chan.run_length),
  .run_value   (out_chan.run_value),
  .pair_number (out_chan.pair_number),
  .last_pair   (out_chan.last_pair)
);

[tb/tb_rgb565_run_length_encoder.sv]
// Self-checking testbench for rgb565_run_length_encoder: drives pixel items, predicts the
// (length, value) pairs of each frame and checks every pair that leaves the encoder.
// Depends on rgb_rle_pkg, rgb_rle_pix_if, rgb_rle_pair_if and the encoder itself.
module tb_rgb565_run_length_encoder;

  localparam int CLK_HALF     = 4;
  localparam int CYCLE_LIMIT  = 2_000_000;
  localparam int RANDOM_ITEMS = 1100;
  localparam int LONG_HOLD    = 300;
  localparam int TAIL_CYCLES  = 16;

  typedef struct packed {
    logic [rgb_rle_pkg::PIX_W-1:0] pixel;
    logic                          frame_end;
  } pixel_item_t;

  logic clk;
  logic rst_n;

  rgb_rle_pix_if  in_chan ();
  rgb_rle_pair_if out_chan ();

  rgb565_run_length_encoder dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  pixel_item_t         pending_pixels[$];
  rgb_rle_pkg::pair_t  expected_pairs[$];

  // Encoder state as the predictor sees it.
  logic [rgb_rle_pkg::PIX_W-1:0] run_val;
  logic [rgb_rle_pkg::LEN_W-1:0] run_len;
  logic [rgb_rle_pkg::NUM_W-1:0] pair_count;

  int          mismatches;
  int unsigned cycle_count;
  bit          calm;
  bit          hold_request;

  int send_gap;
  int send_mode_left;
  bit send_quiet;
  int stall_left;
  int recv_mode_left;
  bit recv_quiet;
  int hold_left;
  bit hold_done;

  initial begin
    clk   = 1'b0;
    rst_n = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Mostly no gap, sometimes a short one and now and then a long one.
  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic void queue_pixel(logic [rgb_rle_pkg::PIX_W-1:0] px, logic fe);
    pending_pixels.push_back('{pixel: px, frame_end: fe});
  endfunction

  function automatic void close_run(logic last);
    pair_count = pair_count + rgb_rle_pkg::NUM_W'(1);
    expected_pairs.push_back('{run_length: run_len, run_value: run_val,
                               pair_number: pair_count, last_pair: last});
    run_len = '0;
  endfunction

  function automatic void encode_pixel(logic [rgb_rle_pkg::PIX_W-1:0] px, logic fe);
    if (run_len != '0 && px != run_val) close_run(1'b0);
    if (run_len == '0) begin
      run_val = px;
      run_len = rgb_rle_pkg::LEN_W'(1);
    end else begin
      run_len = run_len + rgb_rle_pkg::LEN_W'(1);
    end
    // A full run is closed at once; the last pixel of a frame flushes whatever is open.
    if (run_len == rgb_rle_pkg::RUN_MAX || fe) close_run(fe);
    if (fe) pair_count = '0;
  endfunction

  task automatic report_mismatch(string msg);
    mismatches++;
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
  endtask

  task automatic check_field(string name, logic [rgb_rle_pkg::NUM_W-1:0] want,
                             logic [rgb_rle_pkg::NUM_W-1:0] got);
    if (want !== got)
      report_mismatch($sformatf("%s expected %0d got %0d", name, want, got));
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_pixels.size() != 0 || in_chan.valid || expected_pairs.size() != 0);
  endtask

  // Pixel driver: takes the next item from the pending queue once the current one is gone.
  always @(posedge clk) begin
    pixel_item_t nxt;
    if (!rst_n) begin
      in_chan.valid     <= 1'b0;
      in_chan.pixel     <= '0;
      in_chan.frame_end <= 1'b0;
      run_val           = '0;
      run_len           = '0;
      pair_count        = '0;
      send_gap          = 0;
      send_mode_left    = 0;
      send_quiet        = 1'b0;
    end else begin
      if (in_chan.valid && in_chan.ready) encode_pixel(in_chan.pixel, in_chan.frame_end);
      if (!in_chan.valid || in_chan.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_chan.valid <= 1'b0;
        end else if (pending_pixels.size() != 0) begin
          nxt = pending_pixels.pop_front();
          in_chan.pixel     <= nxt.pixel;
          in_chan.frame_end <= nxt.frame_end;
          in_chan.valid     <= 1'b1;
          if (send_mode_left == 0) begin
            send_quiet     = ($urandom_range(0, 2) == 0);
            send_mode_left = $urandom_range(10, 80);
          end
          send_mode_left--;
          send_gap = (calm || send_quiet) ? 0 : draw_gap();
        end else begin
          in_chan.valid <= 1'b0;
        end
      end
    end
  end

  // Pair receiver: random stalls, plus one long hold-off that backs the encoder up.
  always @(posedge clk) begin
    int g;
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
      stall_left     = 0;
      recv_mode_left = 0;
      recv_quiet     = 1'b0;
      hold_left      = 0;
      hold_done      = 1'b0;
    end else begin
      if (hold_request && !hold_done) begin
        hold_done = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_chan.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_chan.ready <= 1'b0;
      end else begin
        if (recv_mode_left == 0) begin
          recv_quiet     = ($urandom_range(0, 2) == 0);
          recv_mode_left = $urandom_range(20, 300);
        end
        recv_mode_left--;
        g = (calm || recv_quiet) ? 0 : draw_gap();
        if (g == 0) begin
          out_chan.ready <= 1'b1;
        end else begin
          out_chan.ready <= 1'b0;
          stall_left = g - 1;
        end
      end
    end
  end

  always @(posedge clk) begin
    rgb_rle_pkg::pair_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (expected_pairs.size() == 0) begin
        report_mismatch($sformatf("unexpected pair length %0d value %h number %0d last %0d",
                                  out_chan.run_length, out_chan.run_value,
                                  out_chan.pair_number, out_chan.last_pair));
      end else begin
        want = expected_pairs.pop_front();
        check_field("run_length", rgb_rle_pkg::NUM_W'(want.run_length),
                    rgb_rle_pkg::NUM_W'(out_chan.run_length));
        check_field("run_value", rgb_rle_pkg::NUM_W'(want.run_value),
                    rgb_rle_pkg::NUM_W'(out_chan.run_value));
        check_field("pair_number", want.pair_number, out_chan.pair_number);
        check_field("last_pair", rgb_rle_pkg::NUM_W'(want.last_pair),
                    rgb_rle_pkg::NUM_W'(out_chan.last_pair));
      end
    end
  end

  initial begin
    logic [rgb_rle_pkg::PIX_W-1:0] palette[4];
    logic [rgb_rle_pkg::PIX_W-1:0] v;
    int made;
    int flen;
    int n;
    int rlen;
    int k;

    in_chan.valid     = 1'b0;
    in_chan.pixel     = '0;
    in_chan.frame_end = 1'b0;
    out_chan.ready    = 1'b0;
    calm              = 1'b0;
    hold_request      = 1'b0;
    mismatches        = 0;
    cycle_count       = 0;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Single-pixel frame, then a frame that starts with the value the last one ended on.
    calm = 1'b1;
    queue_pixel(16'h0000, 1'b1);
    queue_pixel(16'h0000, 1'b0);
    queue_pixel(16'h0000, 1'b1);
    queue_pixel(16'hFFFF, 1'b0);
    queue_pixel(16'hFFFF, 1'b0);
    queue_pixel(16'hFFFF, 1'b1);
    // A new value on the last pixel gives two pairs for one item.
    queue_pixel(16'h1234, 1'b0);
    queue_pixel(16'h5678, 1'b1);
    queue_pixel(16'hAAAA, 1'b0);
    queue_pixel(16'hAAAA, 1'b0);
    queue_pixel(16'h5555, 1'b0);
    queue_pixel(16'h5555, 1'b0);
    queue_pixel(16'h5555, 1'b0);
    queue_pixel(16'h8000, 1'b0);
    queue_pixel(16'h7FFF, 1'b1);
    queue_pixel(16'h0001, 1'b0);
    queue_pixel(16'hFFFE, 1'b0);
    queue_pixel(16'hFFFE, 1'b0);
    queue_pixel(16'h0001, 1'b1);
    wait_drained();
    calm = 1'b0;

    hold_request = 1'b1;
    made = 0;
    while (made < RANDOM_ITEMS) begin
      if ($urandom_range(0, 4) != 0) begin
        // Frame built from runs, values drawn mostly from a small palette.
        flen = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 24);
        foreach (palette[i]) palette[i] = rgb_rle_pkg::PIX_W'($urandom_range(0, 16'hFFFF));
        n = 0;
        while (n < flen) begin
          v = ($urandom_range(0, 3) == 0) ? rgb_rle_pkg::PIX_W'($urandom_range(0, 16'hFFFF))
                                          : palette[$urandom_range(0, 3)];
          rlen = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
          for (k = 0; k < rlen && n < flen; k++) begin
            queue_pixel(v, n == flen - 1);
            n++;
          end
        end
        made += flen;
      end else begin
        n = $urandom_range(1, 10);
        for (k = 0; k < n; k++)
          queue_pixel(rgb_rle_pkg::PIX_W'($urandom_range(0, 16'hFFFF)),
                      $urandom_range(0, 7) == 0);
        made += n;
      end
    end
    wait_drained();

    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatches == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/rgb_rle_pkg.sv
hw/rtl/rgb_rle_pix_if.sv
hw/rtl/rgb_rle_pair_if.sv
hw/rtl/rgb565_run_length_encoder.sv
hw/rtl/rgb_rle_chk.sv
tb/tb_rgb565_run_length_encoder.sv
